>>> hdl/lfu_pkg.sv
package lfu_pkg;

  localparam int unsigned MaxFrames = 16;
  localparam int unsigned IdxW      = $clog2(MaxFrames);
  localparam int unsigned PageW     = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned OutW      = 88;

  localparam logic [WordW-1:0] Sat32 = {WordW{1'b1}};

  // One frame of the table as kept in memory
  typedef struct packed {
    logic [PageW-1:0] page;
    logic [WordW-1:0] use_count;
    logic [WordW-1:0] stamp;
  } entry_t;

  // Outcome of comparing one entry against the lookup page and the victim so far
  typedef struct packed {
    logic page_eq;
    logic count_lt;
    logic count_eq;
    logic stamp_lt;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
    sat_inc = (v == Sat32) ? v : v + WordW'(1);
  endfunction

endpackage

>>> hdl/lfu_table.sv
module lfu_table
  import lfu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW-1:0]      rd_addr_i,
  output entry_t               rd_data_o,
  output logic [MaxFrames-1:0] valid_o,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  entry_t               wr_data_i
);

  entry_t               mem_q [MaxFrames];
  logic [MaxFrames-1:0] valid_q;

  // Write one frame, read one frame, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

  // Valid bits clear at reset, so the table starts empty without a sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign valid_o = valid_q;

endmodule

>>> hdl/lfu_cmp.sv
module lfu_cmp
  import lfu_pkg::*;
(
  input  entry_t           entry_i,
  input  logic [PageW-1:0] page_i,
  input  logic [WordW-1:0] best_count_i,
  input  logic [WordW-1:0] best_stamp_i,
  output cmp_res_t         res_o
);

  // Match the page and rank the entry against the current victim
  always_comb begin
    res_o.page_eq  = (entry_i.page == page_i);
    res_o.count_lt = (entry_i.use_count < best_count_i);
    res_o.count_eq = (entry_i.use_count == best_count_i);
    res_o.stamp_lt = (entry_i.stamp < best_stamp_i);
  end

endmodule

>>> hdl/lfu_page_replacement.sv
// Sequence: a page is accepted only in idle (frame 0 is read at accept), the active frames
//   (1..16) are scanned in turn through the single table read port and comparator, then
//   the update writes the chosen frame and offers the result; a held result stalls the update.
//   A new page is not accepted until the update is done.
// Reset: asynchronous, active low; the table is empty at once (valid bits clear), stamp
//   and totals clear, the configured frame count returns to 16.
module lfu_page_replacement
  import lfu_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [15:0]     s_axis_tdata,   // [15:0] page_number
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // [0] hit, [4:1] frame_index,
                                          // [5] evicted_valid, [21:6] evicted_page,
                                          // [53:22] hit_total, [85:54] fault_total,
                                          // [87:86] zero
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [CfgW-1:0]  frames_cfg_q;
  logic [IdxW-1:0]  last_idx_q;
  logic [IdxW-1:0]  idx_q;
  logic [PageW-1:0] page_q;
  logic [WordW-1:0] stamp_q;
  logic [WordW-1:0] hit_total_q;
  logic [WordW-1:0] fault_total_q;

  logic             found_q;
  logic [IdxW-1:0]  hit_at_q;
  logic [WordW-1:0] hit_count_q;
  logic             empty_q;
  logic [IdxW-1:0]  empty_at_q;
  logic [IdxW-1:0]  best_idx_q;
  logic [WordW-1:0] best_count_q;
  logic [WordW-1:0] best_stamp_q;
  logic [PageW-1:0] best_page_q;

  logic             out_valid_q;
  logic [OutW-1:0]  out_data_q;

  logic [IdxW-1:0]      rd_addr;
  entry_t               rd_data;
  logic [MaxFrames-1:0] valid_vec;
  logic                 wr_en;
  logic [IdxW-1:0]      target;
  entry_t               wr_data;
  cmp_res_t             cmp;
  logic                 in_fire;
  logic                 upd_go;
  logic                 cur_valid;
  logic                 evict;
  logic [CfgW-1:0]      frames_clamped;
  logic [WordW-1:0]     hit_total_nxt;
  logic [WordW-1:0]     fault_total_nxt;

  lfu_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .valid_o   (valid_vec),
    .wr_en_i   (wr_en),
    .wr_addr_i (target),
    .wr_data_i (wr_data)
  );

  lfu_cmp u_cmp (
    .entry_i      (rd_data),
    .page_i       (page_q),
    .best_count_i (best_count_q),
    .best_stamp_i (best_stamp_q),
    .res_o        (cmp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cur_valid     = valid_vec[idx_q];

  // Clamp the frame count to 1..MaxFrames
  always_comb begin
    frames_clamped = frames_cfg_q;
    if (frames_cfg_q == '0) begin
      frames_clamped = CfgW'(1);
    end else if (frames_cfg_q > CfgW'(MaxFrames)) begin
      frames_clamped = CfgW'(MaxFrames);
    end
  end

  // Sequencer: issue read of frame 0, scan one frame a cycle, then update
  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    upd_go  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_q + IdxW'(1);
        if (idx_q == last_idx_q) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        upd_go = !out_valid_q || m_axis_tready;
        if (upd_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Pick the frame to write and build its new contents
  always_comb begin
    evict = !found_q && !empty_q;
    if (found_q) begin
      target = hit_at_q;
    end else if (empty_q) begin
      target = empty_at_q;
    end else begin
      target = best_idx_q;
    end
    wr_en             = upd_go;
    wr_data.page      = page_q;
    wr_data.use_count = found_q ? sat_inc(hit_count_q) : WordW'(1);
    wr_data.stamp     = stamp_q;
    hit_total_nxt     = found_q ? sat_inc(hit_total_q) : hit_total_q;
    fault_total_nxt   = found_q ? fault_total_q : sat_inc(fault_total_q);
  end

  // Control state and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frames_cfg_q  <= CfgW'(MaxFrames);
      stamp_q       <= '0;
      hit_total_q   <= '0;
      fault_total_q <= '0;
      out_valid_q   <= 1'b0;
      found_q       <= 1'b0;
      empty_q       <= 1'b0;
      idx_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        frames_cfg_q <= cfg_data_i;
      end
      if (in_fire) begin
        stamp_q <= sat_inc(stamp_q);
        found_q <= 1'b0;
        empty_q <= 1'b0;
        idx_q   <= '0;
      end else if (state_q == ST_SCAN) begin
        idx_q <= idx_q + IdxW'(1);
        if (cur_valid) begin
          if (!found_q && cmp.page_eq) begin
            found_q <= 1'b1;
          end
        end else if (!empty_q) begin
          empty_q <= 1'b1;
        end
      end
      if (upd_go) begin
        hit_total_q   <= hit_total_nxt;
        fault_total_q <= fault_total_nxt;
        out_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan payload: hit frame, first empty frame and victim so far
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      page_q     <= s_axis_tdata[PageW-1:0];
      last_idx_q <= IdxW'(frames_clamped - CfgW'(1));
    end else if (state_q == ST_SCAN) begin
      if (cur_valid) begin
        if (!found_q && cmp.page_eq) begin
          hit_at_q    <= idx_q;
          hit_count_q <= rd_data.use_count;
        end
        if (idx_q == '0 || cmp.count_lt || (cmp.count_eq && cmp.stamp_lt)) begin
          best_idx_q   <= idx_q;
          best_count_q <= rd_data.use_count;
          best_stamp_q <= rd_data.stamp;
          best_page_q  <= rd_data.page;
        end
      end else if (!empty_q) begin
        empty_at_q <= idx_q;
      end
    end
    if (upd_go) begin
      out_data_q <= {2'b00, fault_total_nxt, hit_total_nxt,
                     evict ? best_page_q : PageW'(0), evict, target, found_q};
    end
  end

endmodule
